// File: hw/rtl/csddt_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the crop season degree day tracker.
// Holds field widths, event codes and configuration register indexes; no dependencies.
package csddt_pkg;

    localparam int TEMP_W  = 12;
    localparam int DOY_W   = 9;
    localparam int YEAR_W  = 12;
    localparam int DAYS_W  = 10;
    localparam int DD_W    = 24;
    localparam int MEAN_W  = TEMP_W + 1;

    // Start days beyond this one mark a winter crop.
    localparam logic [DOY_W-1:0] WINTER_DAY = DOY_W'(182);
    localparam logic [DOY_W-1:0] FIRST_DAY  = DOY_W'(1);

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_START    = 2'd1,
        EV_BUDBREAK = 2'd2,
        EV_MATURITY = 2'd3
    } event_code_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERENNIAL = 3'd0,
        CFG_BASE      = 3'd1,
        CFG_CUTOFF    = 3'd2,
        CFG_START_DAY = 3'd3,
        CFG_SEASON    = 3'd4
    } cfg_index_t;

endpackage

// File: hw/rtl/crop_season_degree_day_tracker_unit.sv
`timescale 1ns / 1ps
// Top level of the crop season degree day tracker: one daily record in, one result out.
// Depends on csddt_pkg for widths, event codes and register indexes.

// The block takes one daily weather record per cycle and delivers exactly one result per
// record, in the cycle after the input transaction, through an output register; a new record
// is taken in the same cycle in which a waiting result is taken, so the sustained rate is
// one record per clock while m_tready is high. All work for a record (degree day update,
// season start search, maturity count) is one pass of combinational logic into the state
// and result registers. The spring start window is tracked with a shift line of daily
// means and a running sum, so no adder tree over the window is needed. Configuration writes
// are accepted in every cycle and should only be issued while no record is in flight.
module crop_season_degree_day_tracker_unit #(
    parameter int WINDOW_LEN = 7,
    parameter int ACCUM_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input record channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: temp_max[11:0], temp_min[23:12], day_of_year[32:24], year_number[44:33]
    input  logic [47:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: event_day[8:0], degree_days[32:9], season_active[33]
    output logic [39:0] m_tdata,
    // m_tuser: event_code[1:0]
    output logic [1:0]  m_tuser,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [csddt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csddt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int TW     = csddt_pkg::TEMP_W;
    localparam int MW     = csddt_pkg::MEAN_W;
    localparam int DW     = csddt_pkg::DOY_W;
    localparam int YW     = csddt_pkg::YEAR_W;
    localparam int CW     = csddt_pkg::DAYS_W;
    localparam int OW     = csddt_pkg::DD_W;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int WS_W   = MW + 1 + $clog2(WINDOW_LEN);
    localparam int SAT_W  = (ACCUM_BITS > OW) ? ACCUM_BITS : OW;

    // Configuration registers.
    logic                 perennial_reg;
    logic signed [TW-1:0] base_reg;
    logic signed [TW-1:0] cutoff_reg;
    logic [DW-1:0]        start_day_reg;
    logic [CW-1:0]        season_days_reg;

    // Tracker state.
    logic [ACCUM_BITS-1:0] dd_sum_reg, dd_sum_next;
    logic [CW-1:0]         days_reg, days_next;
    logic                  season_on_reg, season_on_next;
    logic                  warm_found_reg, warm_found_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [YW-1:0]         finished_reg, finished_next;
    logic signed [WS_W-1:0] win_sum_reg, win_sum_next;
    logic signed [MW-1:0]  win_reg [WINDOW_LEN];
    logic                  win_push;

    // Result register.
    logic                  m_tvalid_reg;
    csddt_pkg::event_code_t code_reg, code_next;
    logic [DW-1:0]         eday_reg, eday_next;
    logic [OW-1:0]         edd_reg, edd_next;
    logic                  active_reg;

    logic accept;

    // Input fields.
    logic signed [TW-1:0] temp_max;
    logic signed [TW-1:0] temp_min;
    logic [DW-1:0]        day_of_year;
    logic [YW-1:0]        year_number;

    assign temp_max    = $signed(s_tdata[11:0]);
    assign temp_min    = $signed(s_tdata[23:12]);
    assign day_of_year = s_tdata[32:24];
    assign year_number = s_tdata[44:33];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Degree day arithmetic, all in 1/32 degree C.
    logic signed [MW-1:0]   mean2;
    logic signed [MW-1:0]   base2;
    logic signed [MW-1:0]   cut2;
    logic signed [MW-1:0]   capped;
    logic signed [MW:0]     incr;
    logic                   warm_day;
    logic [ACCUM_BITS-1:0]  acc_in;
    logic signed [ACCUM_BITS+1:0] acc_sum;
    logic [ACCUM_BITS-1:0]  acc_out;

    assign mean2  = $signed({temp_max[TW-1], temp_max}) + $signed({temp_min[TW-1], temp_min});
    assign base2  = $signed({base_reg, 1'b0});
    assign cut2   = $signed({cutoff_reg, 1'b0});
    assign capped = (mean2 > cut2) ? cut2 : mean2;
    assign incr   = $signed({capped[MW-1], capped}) - $signed({base2[MW-1], base2});
    assign warm_day = mean2 > base2;
    assign acc_sum = $signed({2'b00, acc_in})
                   + $signed({{(ACCUM_BITS + 1 - MW){incr[MW]}}, incr});

    // The sum stops at zero and at its top value.
    always_comb begin
        if (!warm_day) begin
            acc_out = acc_in;
        end else if (acc_sum[ACCUM_BITS+1]) begin
            acc_out = '0;
        end else if (acc_sum[ACCUM_BITS]) begin
            acc_out = '1;
        end else begin
            acc_out = acc_sum[ACCUM_BITS-1:0];
        end
    end

    // Start window: running sum of the last WINDOW_LEN daily means.
    logic                    win_full;
    logic signed [WS_W-1:0]  mean_ext;
    logic signed [WS_W-1:0]  oldest_ext;
    logic signed [WS_W-1:0]  win_sum_push;
    logic [FILL_W-1:0]       fill_push;
    logic signed [WS_W-1:0]  win_limit;
    logic                    win_warm;

    assign win_full   = fill_reg == FILL_W'(WINDOW_LEN);
    assign mean_ext   = WS_W'(mean2);
    assign oldest_ext = WS_W'(win_reg[0]);
    assign win_limit  = $signed(WS_W'(WINDOW_LEN)) * $signed(WS_W'(base2));

    always_comb begin
        if (win_full) begin
            win_sum_push = win_sum_reg - oldest_ext + mean_ext;
            fill_push    = fill_reg;
        end else if (fill_reg == '0) begin
            win_sum_push = mean_ext;
            fill_push    = FILL_W'(1);
        end else begin
            win_sum_push = win_sum_reg + mean_ext;
            fill_push    = fill_reg + FILL_W'(1);
        end
    end

    assign win_warm = (fill_push == FILL_W'(WINDOW_LEN)) && (win_sum_push > win_limit);

    // Per-record update.
    logic                  is_first_day;
    logic                  is_winter;
    logic                  season_mid;
    logic [CW-1:0]         days_mid;
    logic                  use_edd;
    logic [ACCUM_BITS-1:0] edd_acc;
    logic [SAT_W-1:0]      edd_wide;

    assign is_first_day = day_of_year == csddt_pkg::FIRST_DAY;
    assign is_winter    = start_day_reg > csddt_pkg::WINTER_DAY;

    always_comb begin
        dd_sum_next     = dd_sum_reg;
        days_next       = days_reg;
        season_on_next  = season_on_reg;
        warm_found_next = warm_found_reg;
        fill_next       = fill_reg;
        win_sum_next    = win_sum_reg;
        finished_next   = finished_reg;
        win_push        = 1'b0;
        code_next       = csddt_pkg::EV_NONE;
        eday_next       = '0;
        use_edd         = 1'b0;
        edd_acc         = '0;
        acc_in          = dd_sum_reg;
        season_mid      = season_on_reg;
        days_mid        = days_reg;

        if (perennial_reg) begin
            if (year_number != finished_reg) begin
                if (is_first_day) begin
                    acc_in = '0;
                end else if (day_of_year == start_day_reg) begin
                    code_next  = csddt_pkg::EV_BUDBREAK;
                    eday_next  = day_of_year;
                    edd_acc    = dd_sum_reg;
                    use_edd    = 1'b1;
                    acc_in     = '0;
                    season_mid = 1'b1;
                    days_mid   = '0;
                end
                dd_sum_next    = acc_out;
                season_on_next = season_mid;
                days_next      = days_mid;
                if (season_mid) begin
                    if (days_mid < season_days_reg) begin
                        days_next = days_mid + CW'(1);
                    end else begin
                        code_next      = csddt_pkg::EV_MATURITY;
                        eday_next      = day_of_year;
                        edd_acc        = acc_out;
                        use_edd        = 1'b1;
                        season_on_next = 1'b0;
                        finished_next  = year_number;
                    end
                end
            end
        end else if (year_number != finished_reg || is_winter) begin
            if (is_first_day) begin
                warm_found_next = 1'b0;
            end else if (season_on_reg) begin
                fill_next = '0;
                if (days_reg < season_days_reg) begin
                    dd_sum_next = acc_out;
                    days_next   = days_reg + CW'(1);
                end else begin
                    code_next      = csddt_pkg::EV_MATURITY;
                    eday_next      = day_of_year;
                    edd_acc        = dd_sum_reg;
                    use_edd        = 1'b1;
                    season_on_next = 1'b0;
                    finished_next  = year_number;
                end
            end else begin
                if (is_winter) begin
                    season_on_next = day_of_year > start_day_reg;
                end else begin
                    win_push        = 1'b1;
                    fill_next       = fill_push;
                    win_sum_next    = win_sum_push;
                    warm_found_next = warm_found_reg || win_warm;
                    season_on_next  = warm_found_next && (day_of_year >= start_day_reg);
                end
                if (season_on_next) begin
                    days_next   = '0;
                    dd_sum_next = '0;
                    code_next   = csddt_pkg::EV_START;
                    eday_next   = day_of_year;
                    edd_acc     = '0;
                    use_edd     = 1'b1;
                end
            end
        end

        if (!use_edd) begin
            edd_acc = dd_sum_next;
        end
        edd_wide = SAT_W'(edd_acc);
        if (edd_wide > SAT_W'({OW{1'b1}})) begin
            edd_next = '1;
        end else begin
            edd_next = edd_wide[OW-1:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perennial_reg   <= 1'b0;
            base_reg        <= '0;
            cutoff_reg      <= TW'(480);
            start_day_reg   <= DW'(90);
            season_days_reg <= CW'(120);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                csddt_pkg::CFG_PERENNIAL: perennial_reg   <= cfg_data[0];
                csddt_pkg::CFG_BASE:      base_reg        <= $signed(cfg_data[TW-1:0]);
                csddt_pkg::CFG_CUTOFF:    cutoff_reg      <= $signed(cfg_data[TW-1:0]);
                csddt_pkg::CFG_START_DAY: start_day_reg   <= cfg_data[DW-1:0];
                csddt_pkg::CFG_SEASON:    season_days_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Tracker state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dd_sum_reg     <= '0;
            days_reg       <= '0;
            season_on_reg  <= 1'b0;
            warm_found_reg <= 1'b0;
            fill_reg       <= '0;
            win_sum_reg    <= '0;
            finished_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                dd_sum_reg     <= dd_sum_next;
                days_reg       <= days_next;
                season_on_reg  <= season_on_next;
                warm_found_reg <= warm_found_next;
                fill_reg       <= fill_next;
                win_sum_reg    <= win_sum_next;
                finished_reg   <= finished_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    // Window shift line and result payload.
    always_ff @(posedge aclk) begin
        if (accept && win_push) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW_LEN-1] <= mean2;
        end
        if (accept) begin
            code_reg   <= code_next;
            eday_reg   <= eday_next;
            edd_reg    <= edd_next;
            active_reg <= season_on_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = code_reg;
    assign m_tdata  = {6'b0, active_reg, edd_reg, eday_reg};

endmodule

// File: dv/csddt_result_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the crop season degree day tracker: tracks configuration writes,
// predicts one result per accepted daily record and compares it with the result channel.
// Depends on csddt_pkg for widths, event codes and register indexes.
module csddt_result_checker
    import csddt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [47:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int WIN_LEN = 7;
    localparam longint DD_TOP = (longint'(1) << DD_W) - 1;

    typedef struct packed {
        event_code_t       code;
        logic [DOY_W-1:0]  day;
        logic [DD_W-1:0]   dd;
        logic              active;
    } season_result_t;

    // Register copies.
    logic                     cfg_perennial;
    logic signed [TEMP_W-1:0] cfg_base;
    logic signed [TEMP_W-1:0] cfg_cutoff;
    logic [DOY_W-1:0]         cfg_start;
    logic [DAYS_W-1:0]        cfg_season;

    // Tracker state.
    logic [DD_W-1:0]          dd_sum;
    logic [DAYS_W-1:0]        days_cnt;
    logic                     season_on;
    logic                     warm_found;
    logic signed [MEAN_W-1:0] win_means [WIN_LEN];
    logic [3:0]               win_fill;
    logic [YEAR_W-1:0]        done_year;

    season_result_t season_results_due [$];
    season_result_t want;
    int err_cnt = 0;
    int result_idx = 0;

    function automatic void add_degree_days(input int mean2);
        int base2;
        int cut2;
        int capped;
        longint nxt;
        base2 = 2 * cfg_base;
        cut2 = 2 * cfg_cutoff;
        if (mean2 > base2) begin
            capped = (mean2 > cut2) ? cut2 : mean2;
            nxt = longint'(dd_sum) + longint'(capped - base2);
            if (nxt < 0)
                nxt = 0;
            if (nxt > DD_TOP)
                nxt = DD_TOP;
            dd_sum = nxt[DD_W-1:0];
        end
    endfunction

    // Slides the daily mean into the spring window; true once the full window is warm.
    function automatic bit slide_warm_window(input int mean2);
        int total;
        total = 0;
        if (win_fill >= WIN_LEN) begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                win_means[i] = win_means[i+1];
            win_means[WIN_LEN-1] = mean2[MEAN_W-1:0];
        end else begin
            win_means[win_fill] = mean2[MEAN_W-1:0];
            win_fill = win_fill + 1;
        end
        if (win_fill < WIN_LEN)
            return 1'b0;
        for (int i = 0; i < WIN_LEN; i++)
            total += win_means[i];
        return total > WIN_LEN * 2 * cfg_base;
    endfunction

    function automatic season_result_t predict_day(input logic [47:0] rec);
        logic signed [TEMP_W-1:0] t_hi;
        logic signed [TEMP_W-1:0] t_lo;
        logic [DOY_W-1:0]         doy;
        logic [YEAR_W-1:0]        yr;
        int                       mean2;
        bit                       winter;
        bit                       dd_taken;
        season_result_t           r;
        t_hi = rec[11:0];
        t_lo = rec[23:12];
        doy = rec[32:24];
        yr = rec[44:33];
        mean2 = t_hi + t_lo;
        r.code = EV_NONE;
        r.day = '0;
        r.dd = '0;
        dd_taken = 1'b0;
        if (cfg_perennial) begin
            if (yr != done_year) begin
                if (doy == FIRST_DAY) begin
                    dd_sum = '0;
                end else if (doy == cfg_start) begin
                    r.code = EV_BUDBREAK;
                    r.day = doy;
                    r.dd = dd_sum;
                    dd_taken = 1'b1;
                    dd_sum = '0;
                    season_on = 1'b1;
                    days_cnt = '0;
                end
                add_degree_days(mean2);
                if (season_on) begin
                    if (days_cnt < cfg_season) begin
                        days_cnt = days_cnt + 1;
                    end else begin
                        // Maturity overrides a budbreak reported on the same day.
                        r.code = EV_MATURITY;
                        r.day = doy;
                        r.dd = dd_sum;
                        dd_taken = 1'b1;
                        season_on = 1'b0;
                        done_year = yr;
                    end
                end
            end
        end else begin
            winter = cfg_start > WINTER_DAY;
            // Winter crops span the year boundary, so a finished year does not stop them.
            if (yr != done_year || winter) begin
                if (doy == FIRST_DAY) begin
                    warm_found = 1'b0;
                end else if (season_on) begin
                    win_fill = '0;
                    if (days_cnt < cfg_season) begin
                        add_degree_days(mean2);
                        days_cnt = days_cnt + 1;
                    end else begin
                        r.code = EV_MATURITY;
                        r.day = doy;
                        r.dd = dd_sum;
                        dd_taken = 1'b1;
                        season_on = 1'b0;
                        done_year = yr;
                    end
                end else begin
                    if (winter) begin
                        if (doy > cfg_start)
                            season_on = 1'b1;
                    end else begin
                        if (slide_warm_window(mean2))
                            warm_found = 1'b1;
                        if (warm_found && doy >= cfg_start)
                            season_on = 1'b1;
                    end
                    if (season_on) begin
                        days_cnt = '0;
                        dd_sum = '0;
                        r.code = EV_START;
                        r.day = doy;
                        r.dd = '0;
                        dd_taken = 1'b1;
                    end
                end
            end
        end
        if (!dd_taken)
            r.dd = dd_sum;
        r.active = season_on;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            if (err_cnt < 10)
                $display("result %0d: %s expected %0d, got %0d",
                         result_idx, what, exp_val, got_val);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_perennial = 1'b0;
            cfg_base = 12'sd0;
            cfg_cutoff = 12'sd480;
            cfg_start = 9'd90;
            cfg_season = 10'd120;
            dd_sum = '0;
            days_cnt = '0;
            season_on = 1'b0;
            warm_found = 1'b0;
            win_fill = '0;
            done_year = '0;
            season_results_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PERENNIAL: cfg_perennial = cfg_data[0];
                    CFG_BASE:      cfg_base = cfg_data;
                    CFG_CUTOFF:    cfg_cutoff = cfg_data;
                    CFG_START_DAY: cfg_start = cfg_data[DOY_W-1:0];
                    CFG_SEASON:    cfg_season = cfg_data[DAYS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                season_results_due.push_back(predict_day(s_tdata));
            if (m_tvalid && m_tready) begin
                if (season_results_due.size() == 0) begin
                    if (err_cnt < 10)
                        $display("result %0d arrived with no record waiting", result_idx);
                    err_cnt++;
                end else begin
                    want = season_results_due.pop_front();
                    check_field("event_code", want.code, m_tuser);
                    check_field("event_day", want.day, m_tdata[8:0]);
                    check_field("degree_days", want.dd, m_tdata[32:9]);
                    check_field("season_active", want.active, m_tdata[33]);
                end
                result_idx++;
            end
        end
        pending <= season_results_due.size();
        fail_count <= err_cnt;
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the crop season degree day tracker: clock, reset, record and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on csddt_pkg, the tracker RTL and csddt_result_checker.
module tb;
    import csddt_pkg::*;

    localparam int TEMP_LO = -1280;
    localparam int TEMP_HI = 1120;
    localparam int STALL_LIMIT = 3000;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_PERENNIAL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    bit calm = 1'b0;
    int ready_hold = 0;
    int stuck_cycles = 0;

    crop_season_degree_day_tracker_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csddt_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_temp(input int v);
        return (v < TEMP_LO) ? TEMP_LO : ((v > TEMP_HI) ? TEMP_HI : v);
    endfunction

    // Mostly no gap, some short ones, a few long ones; none at all in calm phases.
    function automatic int idle_len();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
            ready_hold <= idle_len();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_record(input int t_hi, input int t_lo, input int doy, input int yr);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, yr[11:0], doy[8:0], t_lo[11:0], t_hi[11:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Writes all five registers back to back once every result is in.
    task automatic set_regs(input bit mode, input int base, input int cutoff,
                            input int start_day, input int season_len);
        cfg_index_t            order [5];
        logic [CFG_DATA_W-1:0] value [5];
        order[0] = CFG_PERENNIAL;
        order[1] = CFG_BASE;
        order[2] = CFG_CUTOFF;
        order[3] = CFG_START_DAY;
        order[4] = CFG_SEASON;
        value[0] = {{(CFG_DATA_W-1){1'b0}}, mode};
        value[1] = base[CFG_DATA_W-1:0];
        value[2] = cutoff[CFG_DATA_W-1:0];
        value[3] = start_day[CFG_DATA_W-1:0];
        value[4] = season_len[CFG_DATA_W-1:0];
        drain_results();
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++) begin
            cfg_index <= order[i];
            cfg_data <= value[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        bit mode;
        int base;
        int cutoff;
        int start_day;
        int season_len;
        int cur_day;
        int cur_year;
        int t_mid;
        int spread;
        int roll;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Year zero counts as finished right after reset.
        push_record(TEMP_HI, TEMP_HI, 1, 0);

        // Perennial: budbreak and maturity on the same day leave only maturity.
        set_regs(1'b1, 0, TEMP_HI, 3, 0);
        push_record(TEMP_HI, TEMP_HI, 1, 5);
        push_record(TEMP_HI, TEMP_LO, 2, 5);
        push_record(TEMP_LO, TEMP_LO, 3, 5);

        // Perennial with the lowest base: budbreak carries the spring sum.
        set_regs(1'b1, TEMP_LO, TEMP_HI, 4, 2);
        push_record(0, 0, 1, 9);
        push_record(TEMP_HI, TEMP_HI, 2, 9);
        push_record(TEMP_LO, -1200, 3, 9);
        push_record(300, 200, 4, 9);
        push_record(600, 500, 5, 9);
        push_record(TEMP_HI, TEMP_LO, 6, 9);

        // Cutoff below base drives the sum down to zero.
        set_regs(1'b1, 100, TEMP_LO, 2, 1);
        push_record(50, 50, 2, 11);
        push_record(1000, 1000, 3, 11);
        push_record(0, 0, 4, 11);

        // Spring crop: the warm window fills, the season starts, then matures.
        set_regs(1'b0, 0, 480, 2, 1);
        push_record(100, 100, 1, 12);
        for (int d = 2; d <= 8; d++)
            push_record(100, 100, d, 12);
        push_record(900, 900, 9, 12);
        push_record(200, 100, 10, 12);

        // Winter crop on the last day of the last year.
        set_regs(1'b0, 0, 480, 365, 1);
        push_record(TEMP_LO, TEMP_HI, 366, 4095);
        push_record(TEMP_LO, TEMP_HI, 366, 4095);
        push_record(TEMP_LO, TEMP_HI, 366, 4095);
        push_record(500, 400, 2, 0);

        cur_year = rand_span(13, 4000);
        cur_day = 1;
        for (int phase = 0; phase < 12; phase++) begin
            mode = $urandom_range(0, 1);
            base = ($urandom_range(0, 3) == 0) ? rand_span(TEMP_LO, TEMP_HI) : rand_span(-40, 200);
            cutoff = ($urandom_range(0, 6) == 0) ? rand_span(TEMP_LO, TEMP_HI)
                                                 : clamp_temp(base + rand_span(80, 600));
            roll = $urandom_range(0, 99);
            if (roll < 50)
                start_day = rand_span(1, 182);
            else if (roll < 85)
                start_day = rand_span(183, 366);
            else begin
                case ($urandom_range(0, 3))
                    0: start_day = 1;
                    1: start_day = 182;
                    2: start_day = 183;
                    default: start_day = 366;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 70)
                season_len = rand_span(0, 25);
            else if (roll < 90)
                season_len = rand_span(26, 80);
            else
                season_len = ($urandom_range(0, 1) != 0) ? 1023 : 0;
            if (phase == 0) begin
                mode = 1'b0;
                base = TEMP_LO;
                cutoff = TEMP_HI;
                start_day = 1;
                season_len = 0;
            end else if (phase == 1) begin
                mode = 1'b1;
                base = TEMP_HI;
                cutoff = TEMP_LO;
                start_day = 366;
                season_len = 1023;
            end
            set_regs(mode, base, cutoff, start_day, season_len);
            calm = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 1) != 0)
                cur_day = rand_span(1, 366);
            else
                cur_day = (start_day > 30) ? start_day - rand_span(0, 30) : 1;

            for (int n = 0; n < 110; n++) begin
                if (n == 60 && $urandom_range(0, 2) == 0)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    push_record(rand_span(TEMP_LO, TEMP_HI), rand_span(TEMP_LO, TEMP_HI),
                                rand_span(0, 511),
                                ($urandom_range(0, 1) != 0) ? cur_year : rand_span(0, 4095));
                end else begin
                    // A few broken sequences step back into the previous year.
                    if (roll < 11)
                        cur_year = (cur_year + 4095) % 4096;
                    if ($urandom_range(0, 99) < 70)
                        cur_day = cur_day + 1;
                    else
                        cur_day = cur_day + rand_span(2, 12);
                    if (cur_day > 366 || $urandom_range(0, 49) == 0) begin
                        cur_day = 1;
                        cur_year = (cur_year + 1) % 4096;
                    end
                    t_mid = base + rand_span(-200, 260);
                    spread = rand_span(0, 240);
                    push_record(clamp_temp(t_mid + spread), clamp_temp(t_mid - spread),
                                cur_day, cur_year);
                end
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
